### rtl/core/vic_pkg.sv
// Shared types and constants for the vertex index compactor.
// No dependencies; imported by every module of the block.
package vic_pkg;

   localparam int MAX_UNIQUE   = 256;
   localparam int MAX_BOUNDARY = 256;

   localparam int KEY_W   = 32;
   localparam int LOCAL_W = 8;
   localparam int ACT_W   = 2;

   localparam int SEEN_AW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
   localparam int SEEN_CW = $clog2(MAX_UNIQUE + 1);
   localparam int BND_AW  = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
   localparam int BND_CW  = $clog2(MAX_BOUNDARY + 1);

   // action codes of an input item
   localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BOUNDARY = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMAP    = 2'd2;

   // table operations
   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_FIND,
      OP_ADD
   } tbl_op_type;

   typedef struct packed {
      logic             valid;
      tbl_op_type       op;
      logic [KEY_W-1:0] key;
   } tbl_cmd_type;

   typedef struct packed {
      logic               done;
      logic               found;
      logic               inserted;
      logic               overflow;
      logic [SEEN_AW-1:0] pos;
   } seen_status_type;

   typedef struct packed {
      logic done;
      logic found;
   } bnd_status_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [KEY_W-1:0] vertex_index;
   } req_payload_type;

   typedef struct packed {
      logic [LOCAL_W-1:0] local_index;
      logic               is_new;
      logic [KEY_W-1:0]   original_index;
      logic               on_boundary;
      logic               overflow;
   } rsp_payload_type;

endpackage

### rtl/core/vic_seen_table.sv
// Seen-index table: key memory plus fill count, linear scan with insert on miss.
// Depends on vic_pkg.
module vic_seen_table (
   input  logic                      clock,
   input  logic                      reset,
   input  vic_pkg::tbl_cmd_type      cmd,
   output vic_pkg::seen_status_type  status
);
   import vic_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SEEN_CW-1:0] count_ff, count_in;
   logic [SEEN_CW-1:0] addr_ff, addr_in;
   logic               pend_ff, pend_in;
   logic [SEEN_AW-1:0] pend_idx_ff, pend_idx_in;
   seen_status_type    status_ff, status_in;
   logic [KEY_W-1:0]   rd_data_ff;
   logic               wr_en;
   logic               hit;

   logic [KEY_W-1:0]   mem [MAX_UNIQUE];

   assign hit    = pend_ff && (rd_data_ff == key_ff);
   assign status = status_ff;

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      status_in   = '0;
      wr_en       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.valid) begin
               case (cmd.op)
                  OP_CLEAR: begin
                     count_in       = '0;
                     status_in.done = 1'b1;
                  end
                  OP_ADD: begin
                     key_in   = cmd.key;
                     addr_in  = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     status_in.done = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               status_in.done  = 1'b1;
               status_in.found = 1'b1;
               status_in.pos   = pend_idx_ff;
               state_in        = S_IDLE;
            end else if (addr_ff == count_ff) begin
               // every valid entry compared, none matched
               status_in.done = 1'b1;
               if (count_ff < SEEN_CW'(MAX_UNIQUE)) begin
                  wr_en              = 1'b1;
                  status_in.inserted = 1'b1;
                  status_in.pos      = count_ff[SEEN_AW-1:0];
                  count_in           = count_ff + 1'b1;
               end else begin
                  status_in.overflow = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               pend_in     = 1'b1;
               pend_idx_in = addr_ff[SEEN_AW-1:0];
               addr_in     = addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         addr_ff   <= '0;
         pend_ff   <= 1'b0;
         status_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         addr_ff   <= addr_in;
         pend_ff   <= pend_in;
         status_ff <= status_in;
      end
      key_ff      <= key_in;
      pend_idx_ff <= pend_idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[SEEN_AW-1:0]] <= key_ff;
      end
      rd_data_ff <= mem[addr_ff[SEEN_AW-1:0]];
   end

endmodule

### rtl/core/vic_bnd_table.sv
// Boundary set: key memory plus fill count, linear scan for find and add-if-absent.
// Depends on vic_pkg.
module vic_bnd_table (
   input  logic                    clock,
   input  logic                    reset,
   input  vic_pkg::tbl_cmd_type    cmd,
   output vic_pkg::bnd_status_type status
);
   import vic_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type         state_ff, state_in;
   tbl_op_type        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [BND_CW-1:0] count_ff, count_in;
   logic [BND_CW-1:0] addr_ff, addr_in;
   logic              pend_ff, pend_in;
   bnd_status_type    status_ff, status_in;
   logic [KEY_W-1:0]  rd_data_ff;
   logic              wr_en;
   logic              hit;

   logic [KEY_W-1:0]  mem [MAX_BOUNDARY];

   assign hit    = pend_ff && (rd_data_ff == key_ff);
   assign status = status_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      pend_in   = 1'b0;
      status_in = '0;
      wr_en     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.valid) begin
               if (cmd.op == OP_CLEAR) begin
                  count_in       = '0;
                  status_in.done = 1'b1;
               end else begin
                  op_in    = cmd.op;
                  key_in   = cmd.key;
                  addr_in  = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               status_in.done  = 1'b1;
               status_in.found = 1'b1;
               state_in        = S_IDLE;
            end else if (addr_ff == count_ff) begin
               status_in.done = 1'b1;
               // add-if-absent; a full set drops the key
               if (op_ff == OP_ADD && count_ff < BND_CW'(MAX_BOUNDARY)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               pend_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         addr_ff   <= '0;
         pend_ff   <= 1'b0;
         status_ff <= '0;
         op_ff     <= OP_FIND;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         addr_ff   <= addr_in;
         pend_ff   <= pend_in;
         status_ff <= status_in;
         op_ff     <= op_in;
      end
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[BND_AW-1:0]] <= key_ff;
      end
      rd_data_ff <= mem[addr_ff[BND_AW-1:0]];
   end

endmodule

### rtl/core/vertex_index_compactor.sv
// Vertex index compactor: one item at a time. A remap scans the seen and boundary tables
// in parallel, each table memory one entry per cycle through its single read port, and
// gives its result once both scans are done. Add-boundary scans and fills the boundary table
// only, clear empties both tables, and an unused action code is accepted with no result.
// A result still waiting when the next remap finishes holds the block. Synchronous reset
// empties both tables (counts to zero) and drops any pending result; memories are not cleared.
module vertex_index_compactor (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  vic_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vic_pkg::rsp_payload_type rsp_payload
);
   import vic_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic             seen_busy_ff, seen_busy_in;
   logic             bnd_busy_ff, bnd_busy_in;
   logic             want_rsp_ff, want_rsp_in;
   logic [KEY_W-1:0] key_ff, key_in;
   seen_status_type  seen_res_ff, seen_res_in;
   logic             bnd_found_ff, bnd_found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   tbl_cmd_type      seen_cmd, bnd_cmd;
   seen_status_type  seen_status;
   bnd_status_type   bnd_status;
   logic             req_fire;
   logic             rsp_free;
   logic             act_clear, act_bnd, act_remap;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign act_clear = (req_payload.action == ACT_CLEAR);
   assign act_bnd   = (req_payload.action == ACT_BOUNDARY);
   assign act_remap = (req_payload.action == ACT_REMAP);

   always_comb begin
      seen_cmd.valid = req_fire && (act_clear || act_remap);
      seen_cmd.op    = act_clear ? OP_CLEAR : OP_ADD;
      seen_cmd.key   = req_payload.vertex_index;
      bnd_cmd.valid  = req_fire && (act_clear || act_bnd || act_remap);
      bnd_cmd.op     = act_clear ? OP_CLEAR : (act_bnd ? OP_ADD : OP_FIND);
      bnd_cmd.key    = req_payload.vertex_index;
   end

   vic_seen_table u_seen (
      .clock  (clock),
      .reset  (reset),
      .cmd    (seen_cmd),
      .status (seen_status)
   );

   vic_bnd_table u_bnd (
      .clock  (clock),
      .reset  (reset),
      .cmd    (bnd_cmd),
      .status (bnd_status)
   );

   always_comb begin
      state_in       = state_ff;
      seen_busy_in   = seen_busy_ff && !seen_status.done;
      bnd_busy_in    = bnd_busy_ff && !bnd_status.done;
      want_rsp_in    = want_rsp_ff;
      key_in         = key_ff;
      seen_res_in    = seen_status.done ? seen_status : seen_res_ff;
      bnd_found_in   = bnd_status.done ? bnd_status.found : bnd_found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         S_IDLE: begin
            // unused action code falls through: no state change, no result
            if (req_fire && (act_clear || act_bnd || act_remap)) begin
               seen_busy_in = seen_cmd.valid;
               bnd_busy_in  = bnd_cmd.valid;
               want_rsp_in  = act_remap;
               key_in       = req_payload.vertex_index;
               state_in     = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!seen_busy_ff && !bnd_busy_ff) begin
               if (!want_rsp_ff) begin
                  state_in = S_IDLE;
               end else if (rsp_free) begin
                  rsp_valid_in                  = 1'b1;
                  rsp_payload_in.local_index    = LOCAL_W'(seen_res_ff.pos);
                  rsp_payload_in.is_new         = seen_res_ff.inserted;
                  rsp_payload_in.original_index = key_ff;
                  rsp_payload_in.on_boundary    = bnd_found_ff;
                  rsp_payload_in.overflow       = seen_res_ff.overflow;
                  state_in                      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_busy_ff <= 1'b0;
         bnd_busy_ff  <= 1'b0;
         want_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_busy_ff <= seen_busy_in;
         bnd_busy_ff  <= bnd_busy_in;
         want_rsp_ff  <= want_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff         <= key_in;
      seen_res_ff    <= seen_res_in;
      bnd_found_ff   <= bnd_found_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

### rtl/core/vic_checker.sv
// Port-level checks for the vertex index compactor, bound to the top level.
// Depends on vic_pkg and vertex_index_compactor.
module vic_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input vic_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input vic_pkg::rsp_payload_type rsp_payload
);
   import vic_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // a new vertex and a full table exclude each other
   a_new_vs_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.is_new && rsp_payload.overflow))
      else $error("is_new and overflow both set");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |-> rsp_payload.local_index == '0)
      else $error("overflow result carries a local index");

   // any real action occupies the block for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_payload.action == ACT_CLEAR || req_payload.action == ACT_BOUNDARY ||
       req_payload.action == ACT_REMAP)
      |=> !req_ready)
      else $error("ready right after accepting an item");

   // a result is produced only by a lookup in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without work in progress");

endmodule

bind vertex_index_compactor vic_checker u_vic_checker (.*);
